// File: sv/a2ra_pkg.sv
// a2ra_pkg: shared types and fixed-point constants for the atan2 pipeline
`default_nettype none
package a2ra_pkg;

	localparam int QBITS      = 30;
	localparam int RATIO_BITS = 16;
	localparam int ANGLE_W    = 16;
	localparam int POLY_W     = 32;

	// rational coefficients, unsigned Q2.30
	localparam logic [31:0] CN_A      = 32'd54011108;
	localparam logic [31:0] CN_B      = 32'd332840025;
	localparam logic [31:0] CN_C      = 32'd158312570;
	localparam logic [31:0] CN_D      = 32'd1073713441;
	localparam logic [31:0] CN_E      = 32'd338;
	localparam logic [31:0] CD_F      = 32'd691988024;
	localparam logic [31:0] CD_G      = 32'd157951624;
	localparam logic [31:0] ONE_Q     = 32'd1073741824;
	localparam logic [31:0] HALF_PI_Q = 32'd1686629713;
	localparam logic [31:0] PI_Q      = 32'd3373259426;

	typedef struct packed {
		logic sw;
		logic nx;
		logic ny;
	} side_t;

endpackage
`default_nettype wire

// File: sv/atan2_rational_approx.sv
// atan2_rational_approx: pipelined four-quadrant arctangent, Q3.13 radians out
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_stall, y_value, x_value | into block
//  out     | out_valid, out_stall, angle      | out of block
//
// one transfer per cycle sustained while out_stall is low
// the depth is set by the two restoring dividers (16 and 30 bit-stages)
// arst_n clears all stage valid bits; payload registers are not reset
// each stage holds while the stage after it is full and held, so bubbles
// close up and in_stall rises only when every stage is full and out_stall is high
`default_nettype none
module atan2_rational_approx
	import a2ra_pkg::*;
#(
	parameter int INPUT_WIDTH     = 16,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [INPUT_WIDTH-1:0] y_value,
	input  wire logic signed [INPUT_WIDTH-1:0] x_value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [ANGLE_W-1:0]          angle
);

	localparam int W      = INPUT_WIDTH;
	localparam int RD_N   = RATIO_BITS;
	localparam int AD_N   = QBITS;
	localparam int ST_RD0 = 3;
	localparam int ST_RS  = ST_RD0 + RD_N;
	localparam int ST_P1  = ST_RS + 1;
	localparam int ST_P4  = ST_P1 + 3;
	localparam int ST_AD0 = ST_P4 + 1;
	localparam int ST_OCT = ST_AD0 + AD_N;
	localparam int NST    = ST_OCT + 1;
	localparam int SH     = QBITS - ANGLE_FRAC_BITS;
	localparam logic [32:0] HALF_STEP = 33'(1) << (SH - 1);

	logic [NST:1]   vld_q;
	logic [NST:1]   vprev;
	logic [NST+1:1] go;

	assign vprev = {vld_q[NST-1:1], in_valid};

	always_comb begin
		go[NST+1] = ~out_stall;
		for (int i = NST; i >= 1; i--) begin
			go[i] = ~vld_q[i] | go[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= NST; i++) begin
				if (go[i]) begin
					vld_q[i] <= vprev[i];
				end
			end
		end
	end

	assign in_stall  = ~go[1];
	assign out_valid = vld_q[NST];

	// magnitudes
	logic [W-1:0] yu, xu, ymag, xmag;
	logic [W-1:0] ay_s1, ax_s1;
	logic         ny_s1, nx_s1;

	assign yu   = y_value;
	assign xu   = x_value;
	assign ymag = yu[W-1] ? (~yu + W'(1)) : yu;
	assign xmag = xu[W-1] ? (~xu + W'(1)) : xu;

	always_ff @(posedge clk) begin
		if (go[1]) begin
			ay_s1 <= ymag;
			ax_s1 <= xmag;
			ny_s1 <= yu[W-1];
			nx_s1 <= xu[W-1];
		end
	end

	// min / max ordering
	logic [W-1:0] mn_s2, mx_s2;
	logic         eq_s2, zr_s2;
	side_t        sb_s2;
	logic         swap;

	assign swap = ay_s1 > ax_s1;

	always_ff @(posedge clk) begin
		if (go[2]) begin
			mn_s2 <= swap ? ax_s1 : ay_s1;
			mx_s2 <= swap ? ay_s1 : ax_s1;
			eq_s2 <= ay_s1 == ax_s1;
			zr_s2 <= (ay_s1 == '0) && (ax_s1 == '0);
			sb_s2 <= '{sw: swap, nx: nx_s1, ny: ny_s1};
		end
	end

	// ratio divider, one quotient bit per stage
	logic [W-1:0]          rd_rem_s [1:RD_N];
	logic [W-1:0]          rd_mx_s  [1:RD_N];
	logic [RATIO_BITS-1:0] rd_q_s   [1:RD_N];
	logic                  rd_eq_s  [1:RD_N];
	logic                  rd_zr_s  [1:RD_N];
	side_t                 rd_sb_s  [1:RD_N];

	for (genvar k = 1; k <= RD_N; k++) begin : g_rd
		logic [W-1:0]          rem_in, mx_in;
		logic [RATIO_BITS-1:0] q_in;
		logic                  eq_in, zr_in;
		side_t                 sb_in;
		logic [W:0]            rem_sh;
		logic                  ge;

		if (k == 1) begin : g_first
			assign rem_in = mn_s2;
			assign mx_in  = mx_s2;
			assign q_in   = '0;
			assign eq_in  = eq_s2;
			assign zr_in  = zr_s2;
			assign sb_in  = sb_s2;
		end else begin : g_next
			assign rem_in = rd_rem_s[k-1];
			assign mx_in  = rd_mx_s[k-1];
			assign q_in   = rd_q_s[k-1];
			assign eq_in  = rd_eq_s[k-1];
			assign zr_in  = rd_zr_s[k-1];
			assign sb_in  = rd_sb_s[k-1];
		end

		assign rem_sh = {rem_in, 1'b0};
		assign ge     = rem_sh >= {1'b0, mx_in};

		always_ff @(posedge clk) begin
			if (go[ST_RD0+k-1]) begin
				rd_rem_s[k] <= ge ? W'(rem_sh - {1'b0, mx_in}) : W'(rem_sh);
				rd_mx_s[k]  <= mx_in;
				rd_q_s[k]   <= {q_in[RATIO_BITS-2:0], ge};
				rd_eq_s[k]  <= eq_in;
				rd_zr_s[k]  <= zr_in;
				rd_sb_s[k]  <= sb_in;
			end
		end
	end

	// ratio select: zero inputs give 0, equal magnitudes saturate
	logic [RATIO_BITS-1:0] ratio_s19;
	side_t                 sb_s19;

	always_ff @(posedge clk) begin
		if (go[ST_RS]) begin
			if (rd_zr_s[RD_N]) begin
				ratio_s19 <= '0;
			end else if (rd_eq_s[RD_N]) begin
				ratio_s19 <= '1;
			end else begin
				ratio_s19 <= rd_q_s[RD_N];
			end
			sb_s19 <= rd_sb_s[RD_N];
		end
	end

	// rational polynomial, horner form, one numerator multiply per stage; the denominator multiplies only in the first two
	logic [POLY_W-1:0]     n1_s20, d1_s20, n2_s21, d2_s21, n3_s22, d2_s22, n4_s23, d2_s23;
	logic [RATIO_BITS-1:0] r_s20, r_s21, r_s22;
	side_t                 sb_s20, sb_s21, sb_s22, sb_s23;
	logic [47:0]           pa, pf, pn2, pd2, pn3, pn4;

	assign pa  = CN_A * ratio_s19;
	assign pf  = CD_F * ratio_s19;
	assign pn2 = n1_s20 * r_s20;
	assign pd2 = d1_s20 * r_s20;
	assign pn3 = n2_s21 * r_s21;
	assign pn4 = n3_s22 * r_s22;

	always_ff @(posedge clk) begin
		if (go[ST_P1]) begin
			n1_s20 <= CN_B - pa[47:16];
			d1_s20 <= pf[47:16] + CD_G;
			r_s20  <= ratio_s19;
			sb_s20 <= sb_s19;
		end
		if (go[ST_P1+1]) begin
			n2_s21 <= pn2[47:16] + CN_C;
			d2_s21 <= pd2[47:16] + ONE_Q;
			r_s21  <= r_s20;
			sb_s21 <= sb_s20;
		end
		if (go[ST_P1+2]) begin
			n3_s22 <= pn3[47:16] + CN_D;
			d2_s22 <= d2_s21;
			r_s22  <= r_s21;
			sb_s22 <= sb_s21;
		end
		if (go[ST_P4]) begin
			n4_s23 <= pn4[47:16] + CN_E;
			d2_s23 <= d2_s22;
			sb_s23 <= sb_s22;
		end
	end

	// num / den in Q2.30, one quotient bit per stage
	logic [POLY_W-1:0] ad_rem_s [1:AD_N];
	logic [POLY_W-1:0] ad_den_s [1:AD_N];
	logic [AD_N-1:0]   ad_q_s   [1:AD_N];
	side_t             ad_sb_s  [1:AD_N];

	for (genvar k = 1; k <= AD_N; k++) begin : g_ad
		logic [POLY_W-1:0] rem_in, den_in;
		logic [AD_N-1:0]   q_in;
		side_t             sb_in;
		logic [POLY_W:0]   rem_sh;
		logic              ge;

		if (k == 1) begin : g_first
			assign rem_in = n4_s23;
			assign den_in = d2_s23;
			assign q_in   = '0;
			assign sb_in  = sb_s23;
		end else begin : g_next
			assign rem_in = ad_rem_s[k-1];
			assign den_in = ad_den_s[k-1];
			assign q_in   = ad_q_s[k-1];
			assign sb_in  = ad_sb_s[k-1];
		end

		assign rem_sh = {rem_in, 1'b0};
		assign ge     = rem_sh >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (go[ST_AD0+k-1]) begin
				ad_rem_s[k] <= ge ? POLY_W'(rem_sh - {1'b0, den_in}) : POLY_W'(rem_sh);
				ad_den_s[k] <= den_in;
				ad_q_s[k]   <= {q_in[AD_N-2:0], ge};
				ad_sb_s[k]  <= sb_in;
			end
		end
	end

	// octant restore
	logic [31:0] ang_s54;
	logic        ny_s54;
	logic [31:0] a_base, a_sw, a_nx;

	assign a_base = 32'(ad_q_s[AD_N]);
	assign a_sw   = ad_sb_s[AD_N].sw ? (HALF_PI_Q - a_base) : a_base;
	assign a_nx   = ad_sb_s[AD_N].nx ? (PI_Q - a_sw) : a_sw;

	always_ff @(posedge clk) begin
		if (go[ST_OCT]) begin
			ang_s54 <= a_nx;
			ny_s54  <= ad_sb_s[AD_N].ny;
		end
	end

	// round to nearest, then apply the sign
	logic [32:0]        rsum, rnd, rres;
	logic [ANGLE_W-1:0] angle_s55;

	assign rsum = {1'b0, ang_s54} + HALF_STEP;
	assign rnd  = rsum >> SH;
	assign rres = ny_s54 ? (33'(0) - rnd) : rnd;

	always_ff @(posedge clk) begin
		if (go[NST]) begin
			angle_s55 <= rres[ANGLE_W-1:0];
		end
	end

	assign angle = angle_s55;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input held while output side can move");

	a_ratio_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[ST_RS-1] && !rd_eq_s[RD_N] && !rd_zr_s[RD_N]) |->
		(rd_rem_s[RD_N] < rd_mx_s[RD_N]))
		else $error("ratio divider remainder out of range");

	a_atan_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[ST_OCT-1] |-> (ad_rem_s[AD_N] < ad_den_s[AD_N]))
		else $error("atan divider remainder out of range");
`endif

endmodule
`default_nettype wire

// File: sim/atan2_checker.sv
// atan2_checker: watches both channels of the atan2 block, predicts each angle and compares
module atan2_checker
	import a2ra_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic signed [15:0] y_value,
	input  wire logic signed [15:0] x_value,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic signed [15:0] angle,
	output int                      errors,
	output int                      pending
);
	logic [15:0] angles_due[$];
	int          angles_seen;

	function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
		logic [63:0] p;
		p = a * b;
		return p >> QBITS;
	endfunction

	function automatic logic [15:0] predict_angle(logic [15:0] yv, logic [15:0] xv);
		logic [63:0] ay, ax, hi, lo, ratio, t, num, den, ang, rnd;
		ay = yv[15] ? (64'd65536 - yv) : {48'd0, yv};
		ax = xv[15] ? (64'd65536 - xv) : {48'd0, xv};
		hi = (ay > ax) ? ay : ax;
		lo = (ay > ax) ? ax : ay;
		ratio = 0;
		if (hi != 0) begin
			ratio = (lo << 16) / hi;
			if (ratio > 64'hFFFF)
				ratio = 64'hFFFF;
		end
		t = ratio << (QBITS - 16);
		num = 64'(CN_B) - fx_mul(64'(CN_A), t);
		num = fx_mul(num, t) + 64'(CN_C);
		num = fx_mul(num, t) + 64'(CN_D);
		num = fx_mul(num, t) + 64'(CN_E);
		den = fx_mul(64'(CD_F), t) + 64'(CD_G);
		den = fx_mul(den, t) + 64'(ONE_Q);
		ang = (num << QBITS) / den;
		if (ay > ax)
			ang = 64'(HALF_PI_Q) - ang;
		if (xv[15])
			ang = 64'(PI_Q) - ang;
		rnd = (ang + (64'd1 << (QBITS - 14))) >> (QBITS - 13);
		if (yv[15])
			rnd = 64'd0 - rnd;
		return rnd[15:0];
	endfunction

	assign pending = angles_due.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors <= 0;
			angles_seen <= 0;
		end else begin
			if (in_valid && !in_stall)
				angles_due.push_back(predict_angle(y_value, x_value));
			if (out_valid && !out_stall) begin
				angles_seen <= angles_seen + 1;
				if (angles_due.size() == 0) begin
					$display("%0t: unexpected angle transfer, got %0d", $time, angle);
					errors <= errors + 1;
				end else begin
					if (angles_due[0] != angle) begin
						$display("%0t: angle expected %0d got %0d", $time,
							$signed(angles_due[0]), angle);
						errors <= errors + 1;
					end
					void'(angles_due.pop_front());
				end
			end
		end
	end
endmodule

// File: sim/tb_top.sv
// tb_top: drives random and corner vector pairs into the atan2 block and reports the verdict
module tb_top;
	import a2ra_pkg::*;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic signed [15:0] y_value = 0;
	logic signed [15:0] x_value = 0;
	logic               out_valid;
	logic               out_stall = 0;
	logic signed [15:0] angle;
	int                 errors, pending;
	int                 cycles = 0;
	bit                 steady = 0;

	localparam int CYCLE_LIMIT = 200000;

	always #1 clk = ~clk;

	atan2_rational_approx u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .y_value(y_value), .x_value(x_value),
		.out_valid(out_valid), .out_stall(out_stall), .angle(angle)
	);

	atan2_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .y_value(y_value), .x_value(x_value),
		.out_valid(out_valid), .out_stall(out_stall), .angle(angle),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("atan2_rational_approx: mismatch");
			$finish;
		end
	end

	// receiver stalls at random except during the steady stretch
	always @(negedge clk)
		out_stall <= !steady && ($urandom_range(99) < 11);

	// one transfer; a gap may precede it
	task automatic send_pair(logic [15:0] yv, logic [15:0] xv);
		while (!steady && $urandom_range(99) < 11) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		y_value <= yv;
		x_value <= xv;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [15:0] rand_field();
		case ($urandom_range(5))
			0: return 16'h8000 + 16'($urandom_range(3));
			1: return 16'h7FFF - 16'($urandom_range(3));
			2: return 16'($urandom_range(8)) - 16'd4;
			3: return 16'($urandom_range(255)) - 16'd128;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [15:0] corner[8];
		logic [15:0] v;
		corner = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
			16'h0064, 16'hFF9C};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		for (int i = 0; i < 5; i++)
			for (int j = 0; j < 5; j++)
				send_pair(corner[i + (i > 2 ? 1 : 0)], corner[j + (j > 2 ? 2 : 0)]);
		send_pair(16'h0064, 16'h0064);
		send_pair(16'hFF9C, 16'h0064);
		send_pair(16'h0000, 16'hFF9C);
		for (int n = 0; n < 700; n++) begin
			steady = (n >= 250 && n < 400);
			if (n == 500) begin
				in_valid <= 0;
				@(negedge clk);
				while (pending != 0)
					@(negedge clk);
			end
			if ($urandom_range(9) == 0) begin
				v = rand_field();
				send_pair(v, $urandom_range(1) ? v : 16'(-v));
			end else begin
				send_pair(rand_field(), rand_field());
			end
		end
		in_valid <= 0;
		steady = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
		$display("covered all four quadrants, axis and diagonal pairs, extreme magnitudes,");
		$display("about 730 transfers with random stalls on both channels and a drain pause");
		if (errors == 0 && pending == 0)
			$display("atan2_rational_approx: match");
		else
			$display("atan2_rational_approx: mismatch");
		$finish;
	end
endmodule
